[rtl/core/elc_pkg.sv]
// Shared types and constants for the LOOK-scheduled elevator controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package elc_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned FLOOR_W  = 4;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QAW      = $clog2(QDEPTH);
  localparam int unsigned QCW      = $clog2(QDEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK      = 3'd0,
    OP_REQUEST   = 3'd1,
    OP_FAULT     = 3'd2,
    OP_RESOLVE   = 3'd3,
    OP_TERMINATE = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_FAULT     = 2'd1,
    MODE_RESOLVE   = 2'd2,
    MODE_TERMINATE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_MODE    = 2'd2
  } kind_e;

  // One classified item as it travels from front to back.
  typedef struct packed {
    kind_e              kind;
    mode_e              mode;
    logic [FLOOR_W-1:0] floor;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_TERM    = 4'd1,
    ST_FAULT   = 4'd2,
    ST_RESOLVE = 4'd3,
    ST_STOP    = 4'd4,
    ST_CLOSE   = 4'd5,
    ST_RECHECK = 4'd6,
    ST_PICK    = 4'd7,
    ST_MOVE    = 4'd8
  } back_state_e;

endpackage

`default_nettype wire

[rtl/core/elevator_look_controller.sv]
// Top level of the single-car LOOK elevator controller.
// Depends on elc_pkg, elc_front, elc_queue and elc_back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   command  | start_i / busy_o        | opcode_i, floor_number_i
//   result   | result_valid_o (strobe) | in_service_o, car_floor_o, travel_dir_o,
//            |                         | door_open_o, last_update_o
//
// Flow: every item passes a two-entry queue, and the back end pops it only while
// its sequencer is idle. Requests and mode commands take effect in the cycle that
// pops them. A tick walks the sequencer through its update states; when terminating,
// the car descends a floor per update until it reaches the ground floor.
// Reset: request map clear, car at ground, stationary, door closed, in service.
// Stalls: busy_o rises only while the queue is full; results are one-cycle
// strobes that the receiver cannot hold off, and last_update_o marks the last
// one of each tick that yields results.
`timescale 1ns / 1ps
`default_nettype none

module elevator_look_controller import elc_pkg::*; #(
  parameter int unsigned NUM_FLOORS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [FLOOR_W-1:0]  floor_number_i,
  output logic                result_valid_o,
  output logic                in_service_o,
  output logic [FLOOR_W-1:0]  car_floor_o,
  output logic [1:0]          travel_dir_o,
  output logic                door_open_o,
  output logic                last_update_o
);

  logic push, q_full, q_valid, q_pop;
  cmd_t push_item, head_item;

  // Classify the item and drop out-of-range floor requests.
  elc_front #(
    .NUM_FLOORS(NUM_FLOORS)
  ) u_front (
    .start_i       (start_i),
    .opcode_i      (opcode_i),
    .floor_number_i(floor_number_i),
    .q_full_i      (q_full),
    .busy_o        (busy_o),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Hold items in order while the back end works through a tick.
  elc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .valid_o(q_valid),
    .item_o (head_item),
    .pop_i  (q_pop)
  );

  // Apply requests and modes; step the car on ticks, at most one update a cycle.
  elc_back #(
    .NUM_FLOORS(NUM_FLOORS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (head_item),
    .q_pop_o       (q_pop),
    .result_valid_o(result_valid_o),
    .in_service_o  (in_service_o),
    .car_floor_o   (car_floor_o),
    .travel_dir_o  (travel_dir_o),
    .door_open_o   (door_open_o),
    .last_update_o (last_update_o)
  );

endmodule

`default_nettype wire

[rtl/core/elc_front.sv]
// Front end: accepts items and classifies them into tick, request or mode commands.
// Depends on elc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module elc_front import elc_pkg::*; #(
  parameter int unsigned NUM_FLOORS = 10
) (
  input  logic                start_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [FLOOR_W-1:0]  floor_number_i,
  input  logic                q_full_i,
  output logic                busy_o,
  output logic                push_o,
  output cmd_t                item_o
);

  logic accept;
  logic in_range;

  assign busy_o   = q_full_i;
  assign accept   = start_i && !q_full_i;
  assign in_range = 32'(floor_number_i) < NUM_FLOORS;

  always_comb begin
    item_o.kind  = KIND_MODE;
    item_o.mode  = MODE_NORMAL;
    item_o.floor = floor_number_i;
    push_o       = accept;
    unique case (opcode_i)
      OP_TICK:      item_o.kind = KIND_TICK;
      OP_REQUEST: begin
        item_o.kind = KIND_REQUEST;
        // drop requests above the top floor
        push_o      = accept && in_range;
      end
      OP_FAULT:     item_o.mode = MODE_FAULT;
      OP_RESOLVE:   item_o.mode = MODE_RESOLVE;
      OP_TERMINATE: item_o.mode = MODE_TERMINATE;
      default:      item_o.mode = MODE_NORMAL;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/elc_queue.sv]
// Short command queue between front and back of the elevator controller.
// Depends on elc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module elc_queue import elc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t item_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t item_o,
  input  logic pop_i
);

  cmd_t           entries_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = count_q == QCW'(QDEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? QAW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? QAW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = QCW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = QCW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QDEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_wrap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (count_q == '0 || count_q == QCW'(QDEPTH)))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[rtl/core/elc_back.sv]
// Back end: car state, request map and the per-tick update sequencer.
// Depends on elc_pkg; fed by elc_queue.
`timescale 1ns / 1ps
`default_nettype none

module elc_back import elc_pkg::*; #(
  parameter int unsigned NUM_FLOORS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cmd_t               q_item_i,
  output logic               q_pop_o,
  output logic               result_valid_o,
  output logic               in_service_o,
  output logic [FLOOR_W-1:0] car_floor_o,
  output logic [1:0]         travel_dir_o,
  output logic               door_open_o,
  output logic               last_update_o
);

  localparam int unsigned FW      = $clog2(NUM_FLOORS);
  localparam logic [FW-1:0] TOP_FLOOR = FW'(NUM_FLOORS - 1);

  back_state_e           state_q, state_d;
  logic [NUM_FLOORS-1:0] req_q, req_d;
  logic [FW-1:0]         floor_q, floor_d;
  dir_e                  dir_q, dir_d;
  logic                  door_q, door_d;
  logic                  svc_q, svc_d;
  mode_e                 mode_q, mode_d;

  logic                  rvalid_q;
  logic                  r_svc_q;
  logic [FLOOR_W-1:0]    r_floor_q;
  dir_e                  r_dir_q;
  logic                  r_door_q;
  logic                  r_last_q;

  logic                  emit, emit_last;
  logic                  up_any, dn_any, pend_up, pend_dn, pend_cur, here_req;
  dir_e                  choice;
  logic [FW-1:0]         req_idx;

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign req_idx  = FW'(q_item_i.floor);
  assign here_req = req_q[floor_q];

  // Look ahead over the request map, both sides of the car, current floor included.
  always_comb begin
    up_any = 1'b0;
    dn_any = 1'b0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (req_q[i] && (FW'(i) >= floor_q)) up_any = 1'b1;
      if (req_q[i] && (FW'(i) <= floor_q)) dn_any = 1'b1;
    end
  end

  assign pend_up = up_any && (floor_q != TOP_FLOOR);
  assign pend_dn = dn_any && (floor_q != '0);
  assign choice  = pend_up ? DIR_UP : (pend_dn ? DIR_DOWN : DIR_STOP);

  always_comb begin
    unique case (dir_q)
      DIR_UP:   pend_cur = pend_up;
      DIR_DOWN: pend_cur = pend_dn;
      default:  pend_cur = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o && q_item_i.kind == KIND_TICK) begin
          unique case (mode_q)
            MODE_TERMINATE: state_d = ST_TERM;
            MODE_FAULT:     state_d = ST_FAULT;
            MODE_RESOLVE:   state_d = ST_RESOLVE;
            MODE_NORMAL:    state_d = svc_q ? ST_STOP : ST_IDLE;
          endcase
        end
      end
      ST_TERM:    if (floor_q == '0) state_d = ST_IDLE;
      ST_FAULT:   state_d = ST_IDLE;
      ST_RESOLVE: state_d = ST_STOP;
      ST_STOP:    state_d = here_req ? ST_CLOSE : ST_PICK;
      ST_CLOSE:   state_d = ST_RECHECK;
      ST_RECHECK: state_d = ST_PICK;
      ST_PICK:    state_d = (dir_q == DIR_STOP && choice == DIR_STOP) ? ST_IDLE : ST_MOVE;
      ST_MOVE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Car state updates and result emission
  always_comb begin
    req_d     = req_q;
    floor_d   = floor_q;
    dir_d     = dir_q;
    door_d    = door_q;
    svc_d     = svc_q;
    mode_d    = mode_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          unique case (q_item_i.kind)
            KIND_REQUEST: req_d[req_idx] = 1'b1;
            KIND_MODE:    mode_d = q_item_i.mode;
            default:      ;
          endcase
        end
      end
      ST_TERM: begin
        emit = 1'b1;
        if (floor_q != '0) begin
          floor_d = FW'(floor_q - 1'b1);
        end else begin
          door_d    = 1'b1;
          dir_d     = DIR_STOP;
          emit_last = 1'b1;
        end
      end
      ST_FAULT: begin
        svc_d     = 1'b0;
        req_d     = '0;
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      ST_RESOLVE: begin
        svc_d  = 1'b1;
        dir_d  = DIR_STOP;
        door_d = 1'b0;
        emit   = 1'b1;
      end
      ST_STOP: begin
        if (here_req) begin
          door_d = 1'b1;
          emit   = 1'b1;
        end
      end
      ST_CLOSE: begin
        req_d[floor_q] = 1'b0;
        door_d         = 1'b0;
        emit           = 1'b1;
      end
      ST_RECHECK: begin
        if (!pend_cur) begin
          dir_d = choice;
          emit  = 1'b1;
        end
      end
      ST_PICK: begin
        if (dir_q == DIR_STOP) begin
          dir_d     = choice;
          emit      = 1'b1;
          emit_last = (choice == DIR_STOP);
        end
      end
      ST_MOVE: begin
        unique case (dir_q)
          DIR_UP: begin
            if (floor_q != TOP_FLOOR) floor_d = FW'(floor_q + 1'b1);
            emit      = 1'b1;
            emit_last = 1'b1;
          end
          DIR_DOWN: begin
            if (floor_q != '0) floor_d = FW'(floor_q - 1'b1);
            emit      = 1'b1;
            emit_last = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      req_q    <= '0;
      floor_q  <= '0;
      dir_q    <= DIR_STOP;
      door_q   <= 1'b0;
      svc_q    <= 1'b1;
      mode_q   <= MODE_NORMAL;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      req_q    <= req_d;
      floor_q  <= floor_d;
      dir_q    <= dir_d;
      door_q   <= door_d;
      svc_q    <= svc_d;
      mode_q   <= mode_d;
      rvalid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      r_svc_q   <= svc_d;
      r_floor_q <= FLOOR_W'(floor_d);
      r_dir_q   <= dir_d;
      r_door_q  <= door_d;
      r_last_q  <= emit_last;
    end
  end

  assign result_valid_o = rvalid_q;
  assign in_service_o   = r_svc_q;
  assign car_floor_o    = r_floor_q;
  assign travel_dir_o   = r_dir_q;
  assign door_open_o    = r_door_q;
  assign last_update_o  = r_last_q;

  a_floor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    floor_q <= TOP_FLOOR)
    else $error("car floor beyond top floor");

  a_last_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && r_last_q) |-> (state_q == ST_IDLE))
    else $error("sequencer still busy after last update");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE))
    else $error("queue popped mid-tick");

  a_term_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && r_last_q && mode_q == MODE_TERMINATE)
      |-> (floor_q == '0 && door_q && dir_q == DIR_STOP))
    else $error("terminate sequence ended away from ground");

endmodule

`default_nettype wire
